// ===== design/pisd_pkg.sv =====
// Package for the partial insertion sort block.
// Word types for the entry and result channels, store entry, FSM states, compare selects.
// No dependencies.
package pisd_pkg;

	localparam int CODE_W  = 16;
	localparam int SCORE_W = 32;

	typedef logic [CODE_W-1:0]         code_t;
	typedef logic signed [SCORE_W-1:0] score_t;

	localparam score_t SORT_LIMIT_RESET = score_t'(32'h8000_0000);

	typedef struct packed {
		code_t  move_code;
		score_t score;
		logic   last_entry;
	} entry_word_t;

	typedef struct packed {
		code_t  out_move_code;
		score_t out_score;
		logic   last_out;
		logic   dropped;
	} result_word_t;

	typedef struct packed {
		code_t  move_code;
		score_t score;
	} store_entry_t;

	typedef enum logic [1:0] {
		CMP_LIMIT,
		CMP_HELD
	} cmp_sel_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_P,
		ST_CHK,
		ST_SWAP,
		ST_WALK,
		ST_PUT,
		ST_E_RD,
		ST_E_LD
	} state_t;

endpackage

// ===== design/pisd_store.sv =====
// Entry store of the partial insertion sort block.
// One write port, one read port with registered read data.
// Depends on pisd_pkg.
module pisd_store
	import pisd_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic         clk,
	input  logic         wr_en,
	input  logic [AW-1:0] wr_addr,
	input  store_entry_t wr_data,
	input  logic         rd_en,
	input  logic [AW-1:0] rd_addr,
	output store_entry_t rd_data
);

	store_entry_t mem_q [DEPTH];
	store_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/pisd_cmp.sv =====
// Shared signed score comparator of the partial insertion sort block.
// Compares a store read against the sort limit or the held entry.
// Depends on pisd_pkg.
module pisd_cmp
	import pisd_pkg::*;
(
	input  cmp_sel_t sel,
	input  score_t   rd_score,
	input  score_t   limit,
	input  score_t   held_score,
	output logic     lt
);

	score_t rhs;

	always_comb begin
		unique case (sel)
			CMP_LIMIT: rhs = limit;
			CMP_HELD:  rhs = held_score;
			default:   rhs = limit;
		endcase
	end

	assign lt = (rd_score < rhs);

endmodule

// ===== design/partial_insertion_sort_descending.sv =====
// Partial insertion sort, descending, over a streamed list of scored entries.
// Depends on pisd_pkg, pisd_store and pisd_cmp.
//
// Entries are taken one a cycle, while entry_stall is low, into a MAX_ENTRIES deep
// store; further entries are dropped and every result of that list carries the
// dropped flag. The entry marked last starts the sort, during which entry_stall
// stays high. The sort runs on one store port pair and one shared comparator: an
// entry below sort_limit is only read and compared; one at or above it is swapped to
// the prefix end, then walked headward past each lower-scored prefix entry. The
// list is then read out in order into the result register; a result stall holds it.
// The first entry of a new list is taken in the cycle after the last result is loaded.
module partial_insertion_sort_descending
	import pisd_pkg::*;
#(
	parameter int MAX_ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  score_t       cfg_wr_data,
	input  logic         entry_valid,
	output logic         entry_stall,
	input  entry_word_t  entry,
	output logic         result_valid,
	input  logic         result_stall,
	output result_word_t result
);

	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	state_t state_q, state_d;

	score_t        sort_limit_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] p_q;
	logic [AW-1:0] pe_q;
	logic [AW-1:0] q_q;
	logic [AW-1:0] k_q;
	store_entry_t  held_q;
	result_word_t  result_q;
	logic          result_valid_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	store_entry_t  mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	store_entry_t  mem_rdata;
	cmp_sel_t      cmp_sel;
	logic          lt;

	logic entry_acc;
	logic result_acc;
	logic out_free;
	logic has_room;
	logic p_in_list;
	logic k_last;
	logic q_at_one;

	assign entry_acc  = entry_valid && !entry_stall;
	assign result_acc = result_valid_q && !result_stall;
	assign out_free   = !result_valid_q || result_acc;
	assign has_room   = (count_q < MAX_CNT);
	assign p_in_list  = (p_q < count_q);
	assign k_last     = ((CW'(k_q) + CW'(1)) == count_q);
	assign q_at_one   = (q_q == AW'(1));

	pisd_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	pisd_cmp u_cmp (
		.sel        (cmp_sel),
		.rd_score   (mem_rdata.score),
		.limit      (sort_limit_q),
		.held_score (held_q.score),
		.lt         (lt)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (entry_acc && entry.last_entry) state_d = ST_RD_P;
			ST_RD_P: state_d = p_in_list ? ST_CHK : ST_E_RD;
			ST_CHK:  state_d = lt ? ST_RD_P : ST_SWAP;
			ST_SWAP: state_d = ST_WALK;
			ST_WALK: begin
				if (lt) begin
					state_d = q_at_one ? ST_PUT : ST_WALK;
				end else begin
					state_d = ST_RD_P;
				end
			end
			ST_PUT:  state_d = ST_RD_P;
			ST_E_RD: if (out_free) state_d = ST_E_LD;
			ST_E_LD: state_d = k_last ? ST_LOAD : ST_E_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		entry_stall = 1'b1;
		mem_we      = 1'b0;
		mem_waddr   = q_q;
		mem_wdata   = held_q;
		mem_re      = 1'b0;
		mem_raddr   = p_q[AW-1:0];
		cmp_sel     = CMP_LIMIT;
		unique case (state_q)
			ST_LOAD: begin
				entry_stall = 1'b0;
				mem_we      = entry_acc && has_room;
				mem_waddr   = count_q[AW-1:0];
				mem_wdata   = '{move_code: entry.move_code, score: entry.score};
			end
			ST_RD_P: begin
				mem_re    = p_in_list;
				mem_raddr = p_q[AW-1:0];
			end
			ST_CHK: begin
				cmp_sel   = CMP_LIMIT;
				mem_re    = !lt;
				mem_raddr = pe_q + AW'(1);
			end
			ST_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = p_q[AW-1:0];
				mem_wdata = mem_rdata;
				mem_re    = 1'b1;
				mem_raddr = q_q - AW'(1);
			end
			ST_WALK: begin
				cmp_sel   = CMP_HELD;
				mem_we    = 1'b1;
				mem_waddr = q_q;
				mem_wdata = lt ? mem_rdata : held_q;
				mem_re    = lt && !q_at_one;
				mem_raddr = q_q - AW'(1) - AW'(1);
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = held_q;
			end
			ST_E_RD: begin
				mem_re    = out_free;
				mem_raddr = k_q;
			end
			ST_E_LD: begin
				mem_re = 1'b0;
			end
			default: begin
				entry_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			sort_limit_q   <= SORT_LIMIT_RESET;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			p_q            <= '0;
			pe_q           <= '0;
			q_q            <= '0;
			k_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				sort_limit_q <= cfg_wr_data;
			end
			if (result_acc) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (entry_acc) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (entry.last_entry) begin
							p_q  <= CW'(1);
							pe_q <= '0;
							k_q  <= '0;
						end
					end
				end
				ST_CHK: begin
					if (lt) begin
						p_q <= p_q + CW'(1);
					end else begin
						pe_q <= pe_q + AW'(1);
						q_q  <= pe_q + AW'(1);
					end
				end
				ST_WALK: begin
					if (lt) begin
						q_q <= q_q - AW'(1);
					end else begin
						p_q <= p_q + CW'(1);
					end
				end
				ST_PUT: p_q <= p_q + CW'(1);
				ST_E_LD: begin
					result_valid_q <= 1'b1;
					k_q            <= k_q + AW'(1);
					if (k_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// hold the entry that the limit comparison picks for insertion, and register the result word
	always_ff @(posedge clk) begin
		if (state_q == ST_CHK && !lt) begin
			held_q <= mem_rdata;
		end
		if (state_q == ST_E_LD) begin
			result_q <= '{out_move_code: mem_rdata.move_code,
			              out_score:     mem_rdata.score,
			              last_out:      k_last,
			              dropped:       ovf_q};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count beyond capacity");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_E_LD))
		else $error("result word raised outside the load step");

	a_sort_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_LOAD) |-> (CW'(mem_waddr) < count_q))
		else $error("sort write outside the stored list");

	a_walk_not_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (q_q != '0))
		else $error("insertion walk past the head of the list");
`endif

endmodule

// ===== verif/partial_insertion_sort_descending_tb.sv =====
// Testbench for partial_insertion_sort_descending: streams scored entry lists under
// several sort limits and idling mixes, predicts each emitted list and checks every word.
// Depends on pisd_pkg and the RTL of the block; reads no files.
module partial_insertion_sort_descending_tb;
	import pisd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     MAX_ENTRIES    = 64;
	localparam int     SETTLE_CYCLES  = 4;
	localparam int     END_CYCLES     = 40;
	localparam int     WATCHDOG_LIMIT = 20000;
	localparam score_t SCORE_MIN      = score_t'(32'h8000_0000);
	localparam score_t SCORE_MAX      = score_t'(32'h7FFF_FFFF);

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         cfg_wr_en    = 1'b0;
	score_t       cfg_wr_data  = '0;
	logic         entry_valid  = 1'b0;
	logic         entry_stall;
	entry_word_t  entry        = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_word_t result;

	store_entry_t loaded_list[$];
	logic         list_overflowed = 1'b0;
	score_t       model_limit     = SORT_LIMIT_RESET;
	result_word_t pending_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int num_lists      = 0;
	int num_entries    = 0;
	int num_results    = 0;
	int num_limits     = 0;
	int num_overflows  = 0;
	int quiet_cycles   = 0;

	partial_insertion_sort_descending #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.entry_valid (entry_valid),
		.entry_stall (entry_stall),
		.entry       (entry),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #1 clk = ~clk;

	function automatic void sort_loaded_list();
		int           prefix_end;
		int           q;
		store_entry_t held;
		prefix_end = 0;
		for (int p = 1; p < loaded_list.size(); p++) begin
			if (loaded_list[p].score >= model_limit) begin
				held = loaded_list[p];
				prefix_end++;
				loaded_list[p] = loaded_list[prefix_end];
				q = prefix_end;
				while (q != 0 && loaded_list[q-1].score < held.score) begin
					loaded_list[q] = loaded_list[q-1];
					q--;
				end
				loaded_list[q] = held;
			end
		end
	endfunction

	function automatic void load_entry(code_t code, score_t score, logic last);
		result_word_t w;
		num_entries++;
		if (loaded_list.size() < MAX_ENTRIES)
			loaded_list.push_back('{move_code: code, score: score});
		else
			list_overflowed = 1'b1;
		if (last) begin
			sort_loaded_list();
			foreach (loaded_list[k]) begin
				w.out_move_code = loaded_list[k].move_code;
				w.out_score     = loaded_list[k].score;
				w.last_out      = (k == loaded_list.size() - 1);
				w.dropped       = list_overflowed;
				pending_results.push_back(w);
			end
			num_lists++;
			if (list_overflowed)
				num_overflows++;
			loaded_list.delete();
			list_overflowed = 1'b0;
		end
	endfunction

	function automatic score_t pick_score();
		case ($urandom_range(3))
			0: return score_t'($urandom);
			1: return model_limit + score_t'($signed($urandom_range(6)) - 3);
			2: begin
				case ($urandom_range(3))
					0: return SCORE_MIN;
					1: return SCORE_MAX;
					2: return score_t'(0);
					default: return score_t'(-1);
				endcase
			end
			default: return score_t'($signed($urandom_range(20)) - 10);
		endcase
	endfunction

	task automatic send_entry(code_t code, score_t score, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			entry_valid <= 1'b0;
			@(posedge clk);
		end
		entry_valid <= 1'b1;
		entry       <= '{move_code: code, score: score, last_entry: last};
		do
			@(posedge clk);
		while (entry_stall);
		load_entry(code, score, last);
	endtask

	task automatic wait_drained();
		entry_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_sort_limit(score_t value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		model_limit = value;
		num_limits++;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_single_entry();
		set_sort_limit(SORT_LIMIT_RESET);
		send_entry(16'h0000, SCORE_MIN, 1'b1);
		send_entry(16'hFFFF, SCORE_MAX, 1'b1);
		wait_drained();
	endtask

	task automatic test_full_sort_extremes();
		send_entry(16'h0001, score_t'(0), 1'b0);
		send_entry(16'h0002, SCORE_MIN, 1'b0);
		send_entry(16'h0003, SCORE_MAX, 1'b0);
		send_entry(16'h0004, score_t'(-1), 1'b0);
		send_entry(16'h0005, score_t'(1), 1'b0);
		send_entry(16'h0006, SCORE_MAX, 1'b1);
		wait_drained();
	endtask

	task automatic test_stable_ties();
		set_sort_limit(score_t'(0));
		send_entry(16'h0010, score_t'(5), 1'b0);
		send_entry(16'h0011, score_t'(-3), 1'b0);
		send_entry(16'h0012, score_t'(5), 1'b0);
		send_entry(16'h0013, score_t'(7), 1'b0);
		send_entry(16'h0014, score_t'(-8), 1'b0);
		send_entry(16'h0015, score_t'(0), 1'b0);
		send_entry(16'h0016, score_t'(5), 1'b0);
		send_entry(16'h0017, score_t'(-1), 1'b1);
		wait_drained();
	endtask

	task automatic test_limit_at_max();
		set_sort_limit(SCORE_MAX);
		send_entry(16'h0020, score_t'(-5), 1'b0);
		send_entry(16'h0021, SCORE_MAX, 1'b0);
		send_entry(16'h0022, SCORE_MAX - 1, 1'b0);
		send_entry(16'h0023, SCORE_MAX, 1'b0);
		send_entry(16'h0024, SCORE_MIN, 1'b1);
		wait_drained();
	endtask

	task automatic test_overflow_drop(score_t limit);
		set_sort_limit(limit);
		for (int i = 0; i < MAX_ENTRIES + 2; i++)
			send_entry(code_t'($urandom), pick_score(), i == MAX_ENTRIES + 1);
		wait_drained();
	endtask

	task automatic test_random_lists(score_t limit, int item_budget);
		int len;
		set_sort_limit(limit);
		while (item_budget > 0) begin
			len = $urandom_range(12, 1);
			if (len > item_budget)
				len = item_budget;
			for (int i = 0; i < len; i++)
				send_entry(code_t'($urandom), pick_score(), i == len - 1);
			item_budget -= len;
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			num_results++;
			if (pending_results.size() == 0) begin
				$error("unexpected result word: code %0h score %0d", result.out_move_code,
					result.out_score);
				error_count++;
			end else begin
				automatic result_word_t want = pending_results.pop_front();
				if (result.out_move_code !== want.out_move_code) begin
					$error("out_move_code: expected %0h, got %0h", want.out_move_code,
						result.out_move_code);
					error_count++;
				end
				if (result.out_score !== want.out_score) begin
					$error("out_score: expected %0d, got %0d", want.out_score, result.out_score);
					error_count++;
				end
				if (result.last_out !== want.last_out) begin
					$error("last_out: expected %0b, got %0b", want.last_out, result.last_out);
					error_count++;
				end
				if (result.dropped !== want.dropped) begin
					$error("dropped: expected %0b, got %0b", want.dropped, result.dropped);
					error_count++;
				end
			end
		end
		result_stall <= arst_n ? ($urandom_range(99) < recv_stall_pct) : 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((entry_valid && !entry_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(27, 87);
		test_single_entry();
		test_full_sort_extremes();
		test_stable_ties();
		test_limit_at_max();
		test_random_lists(score_t'($urandom), 6);

		set_idling(87, 27);
		test_overflow_drop(score_t'($signed($urandom_range(20)) - 10));
		test_random_lists(score_t'(0), 6);

		set_idling(0, 0);
		test_random_lists(SCORE_MIN, 6);
		test_random_lists(score_t'($urandom), 6);

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);

		$display("Covered %0d lists of %0d entries, %0d result words checked,", num_lists,
			num_entries, num_results);
		$display("%0d sort limit writes, %0d overflowing list(s), three idling mixes.",
			num_limits, num_overflows);
		if (error_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/pisd_pkg.sv
design/pisd_store.sv
design/pisd_cmp.sv
design/partial_insertion_sort_descending.sv
verif/partial_insertion_sort_descending_tb.sv
